>>> rtl/ecvgl_pkg.sv
`timescale 1ns / 1ps
package ecvgl_pkg;

	// exponential table geometry
	localparam int EXP_TABLE_BITS = 10;
	localparam int TAB_N          = 1 << EXP_TABLE_BITS;
	localparam int FRAC_SHIFT     = 32 - EXP_TABLE_BITS;
	localparam int ADDR_W         = EXP_TABLE_BITS + 1;
	localparam int INT_N          = 23;
	localparam int INT_W          = 5;

	// t clamp at 22.0 in Q.32
	localparam logic [37:0] T_CLAMP = {6'd22, 32'd0};

	// pipelined divider geometry
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 40;
	localparam int DIV_Q_W   = 48;
	localparam int DIV_LAT   = DIV_Q_W + 1;

	localparam logic signed [47:0] POS_MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] NEG_MIN48 = 48'sh8000_0000_0000;

	// register indexes
	localparam logic [0:0] REG_DECAY_RATE    = 1'b0;
	localparam logic [0:0] REG_CUSP_STRENGTH = 1'b1;

	localparam logic [23:0] DECAY_RESET = 24'd65536;
	localparam logic [23:0] CUSP_RESET  = 24'd65536;

	typedef logic [32:0] q32_t;
	typedef q32_t frac_tab_t [TAB_N + 1];
	typedef q32_t int_tab_t [INT_N];

	typedef struct packed {
		logic [23:0]       decay;
		logic signed [23:0] cusp;
	} cfg_t;

	typedef struct packed {
		logic [23:0]      radius;
		logic             r_zero;
		logic [2:0][23:0] omag;
		logic [2:0]       oneg;
	} item_t;

	typedef struct packed {
		logic signed [47:0] func_value;
		logic signed [47:0] grad_x;
		logic signed [47:0] grad_y;
		logic signed [47:0] grad_z;
		logic signed [47:0] laplacian;
		logic               zero_distance;
	} res_t;

	// exp(-j/2^B) in Q1.32 by truncated taylor series
	function automatic q32_t frac_entry(input int j);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x    = 64'(j) << FRAC_SHIFT;
		term = 64'd1 << 32;
		sum  = 64'sd1 <<< 32;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * (x >> 1)) >> 31) / 64'(k);
			if ((k & 1) != 0) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		if (sum < 0) sum = 64'sd0;
		if (sum > (64'sd1 <<< 32)) sum = 64'sd1 <<< 32;
		return q32_t'(sum);
	endfunction

	function automatic frac_tab_t build_frac_tab();
		frac_tab_t t;
		for (int j = 0; j <= TAB_N; j++) t[j] = frac_entry(j);
		return t;
	endfunction

	// exp(-n) in Q1.32, chained from exp(-1)
	function automatic int_tab_t build_int_tab();
		int_tab_t    t;
		logic [63:0] ft;
		logic [63:0] acc;
		ft   = 64'(frac_entry(TAB_N));
		acc  = 64'd1 << 32;
		t[0] = q32_t'(acc);
		for (int n = 1; n < INT_N; n++) begin
			acc  = (acc * ft + (64'd1 << 31)) >> 32;
			t[n] = q32_t'(acc);
		end
		return t;
	endfunction

endpackage

>>> rtl/ecvgl_front.sv
`timescale 1ns / 1ps
module ecvgl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [23:0]         distance,
	input  logic signed [23:0]  offset_x,
	input  logic signed [23:0]  offset_y,
	input  logic signed [23:0]  offset_z,
	output logic                out_valid,
	input  logic                out_ready,
	output ecvgl_pkg::item_t    out_item
);

	ecvgl_pkg::item_t item_q;
	ecvgl_pkg::item_t cls;
	logic             vld_q;

	function automatic logic [23:0] mag24(input logic signed [23:0] v);
		return v[23] ? 24'(-v) : 24'(v);
	endfunction

	always_comb begin
		cls.radius  = distance;
		cls.r_zero  = (distance == 24'd0);
		cls.omag[0] = mag24(offset_x);
		cls.omag[1] = mag24(offset_y);
		cls.omag[2] = mag24(offset_z);
		cls.oneg    = {offset_z[23], offset_y[23], offset_x[23]};
	end

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= cls;
		end
	end

endmodule

>>> rtl/ecvgl_queue.sv
`timescale 1ns / 1ps
module ecvgl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ecvgl_pkg::item_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output ecvgl_pkg::item_t out_item
);

	localparam int QD  = 2;
	localparam int QPW = 1;

	ecvgl_pkg::item_t mem_q [QD];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QPW:0]     cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != (QPW + 1)'(QD));
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

>>> rtl/ecvgl_exp_rom.sv
`timescale 1ns / 1ps
module ecvgl_exp_rom (
	input  logic                                clk,
	input  logic                                en,
	input  logic [ecvgl_pkg::EXP_TABLE_BITS-1:0] addr,
	output ecvgl_pkg::q32_t                     ent_a,
	output ecvgl_pkg::q32_t                     ent_b
);

	localparam ecvgl_pkg::frac_tab_t FT = ecvgl_pkg::build_frac_tab();

	logic [ecvgl_pkg::ADDR_W-1:0] addr_a;
	logic [ecvgl_pkg::ADDR_W-1:0] addr_b;
	ecvgl_pkg::q32_t              ent_a_q;
	ecvgl_pkg::q32_t              ent_b_q;

	// entry j and its right neighbor for interpolation
	assign addr_a = {1'b0, addr};
	assign addr_b = addr_a + ecvgl_pkg::ADDR_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			ent_a_q <= FT[addr_a];
			ent_b_q <= FT[addr_b];
		end
	end

	assign ent_a = ent_a_q;
	assign ent_b = ent_b_q;

endmodule

>>> rtl/ecvgl_div.sv
`timescale 1ns / 1ps
module ecvgl_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [ecvgl_pkg::DIV_NUM_W-1:0] num,
	input  logic [ecvgl_pkg::DIV_DEN_W-1:0] den,
	output logic [ecvgl_pkg::DIV_Q_W-1:0]   quo,
	output logic                            ovf
);

	localparam int NW = ecvgl_pkg::DIV_NUM_W;
	localparam int DW = ecvgl_pkg::DIV_DEN_W;
	localparam int QW = ecvgl_pkg::DIV_Q_W;
	localparam int HW = NW - QW;

	logic [DW-1:0] rem_q [QW+1];
	logic [QW-1:0] w_q   [QW+1];
	logic [DW-1:0] den_q [QW+1];
	logic          ovf_q [QW+1];

	// restoring division, one quotient bit per stage; w shifts numerator bits
	// out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin : p_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		if (en) begin
			rem_q[0] <= DW'(num[NW-1:QW]);
			w_q[0]   <= num[QW-1:0];
			den_q[0] <= den;
			ovf_q[0] <= (DW'(num[NW-1:QW]) >= den);
			for (int k = 1; k <= QW; k++) begin
				trial    = {rem_q[k-1], w_q[k-1][QW-1]};
				diff     = trial - {1'b0, den_q[k-1]};
				rem_q[k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
				w_q[k]   <= {w_q[k-1][QW-2:0], !diff[DW]};
				den_q[k] <= den_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	assign quo = w_q[QW];
	assign ovf = ovf_q[QW];

endmodule

>>> rtl/ecvgl_back.sv
`timescale 1ns / 1ps
module ecvgl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ecvgl_pkg::cfg_t  cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  ecvgl_pkg::item_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output ecvgl_pkg::res_t  out_res
);

	localparam int FW   = ecvgl_pkg::FRAC_SHIFT;
	localparam int PRE  = 11;
	localparam int VLEN = PRE + ecvgl_pkg::DIV_LAT;
	localparam ecvgl_pkg::int_tab_t IT_TAB = ecvgl_pkg::build_int_tab();

	typedef struct packed {
		logic        eneg;
		logic        ez;
		logic        r_zero;
		logic [2:0]  oz;
		logic [2:0]  oneg;
		logic [32:0] lap_b;
	} side_t;

	logic            en;
	logic [VLEN-1:0] vld_q;
	logic            out_valid_q;
	ecvgl_pkg::res_t res_q;

	ecvgl_pkg::item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	ecvgl_pkg::item_t it_s7, it_s8, it_s9, it_s10, it_s11;

	logic [47:0]    gr;
	logic [37:0]    t_s1;
	logic [4:0]     n_s2, n_s3, n_s4;
	logic [FW-1:0]  rem_s2, rem_s3;
	ecvgl_pkg::q32_t ent_a, ent_b;
	ecvgl_pkg::q32_t a_s3, a_s4, diff_s3;
	logic           dn_s3, dn_s4;
	logic [32+FW:0] prod_s4;
	logic [32:0]    step;
	ecvgl_pkg::q32_t v_s5, v_s6, it_val_s5;
	logic           nz_s5, nz_s6;
	logic [49:0]    pph_s6;
	logic [48:0]    ppl_s6;
	logic [65:0]    ex_sum;
	logic [32:0]    ex_s7;
	logic [23:0]    cm;
	logic [40:0]    cph_s8;
	logic [39:0]    cpl_s8;
	logic           cneg_s8;
	logic [57:0]    e_sum;
	logic [39:0]    emag_s9, emag_s10;
	logic           eneg_s9, eneg_s10;
	logic [2:0][43:0] gph_s10, gpl_s10;
	logic [43:0]    lbh_s10, lbl_s10;
	logic [64:0]    lb_sum;
	logic [2:0][63:0] gnum_s11;
	logic [63:0]    fnum_s11, lnum_s11;
	side_t          side_s11;
	side_t          side_line_q [ecvgl_pkg::DIV_LAT];
	side_t          sd;

	logic [47:0]    f_quo, l_quo;
	logic           f_ovf, l_ovf;
	logic [2:0][47:0] g_quo;
	logic [2:0]     g_ovf;

	// the whole back pipeline moves together, held only by the output beat
	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[VLEN-2:0], in_valid};
			out_valid_q <= vld_q[VLEN-1];
		end
	end

	assign gr = cfg.decay * in_item.radius;

	ecvgl_exp_rom u_rom (
		.clk   (clk),
		.en    (en),
		.addr  (t_s1[31:FW]),
		.ent_a (ent_a),
		.ent_b (ent_b)
	);

	assign step   = 33'(prod_s4 >> FW);
	assign ex_sum = {pph_s6, 16'b0} + 66'(ppl_s6) + (66'd1 << 31);
	assign cm     = cfg.cusp[23] ? 24'(-cfg.cusp) : 24'(cfg.cusp);
	assign e_sum  = {1'b0, cph_s8, 16'b0} + 58'(cpl_s8) + 58'h8000;
	assign lb_sum = {1'b0, lbh_s10, 20'b0} + 65'(lbl_s10) + (65'd1 << 31);

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: t = gamma*r, clamped
			it_s1 <= in_item;
			t_s1  <= (gr > 48'(ecvgl_pkg::T_CLAMP)) ? ecvgl_pkg::T_CLAMP : gr[37:0];
			// s2: table read
			it_s2  <= it_s1;
			n_s2   <= t_s1[36:32];
			rem_s2 <= t_s1[FW-1:0];
			// s3: neighbor difference
			it_s3   <= it_s2;
			n_s3    <= n_s2;
			rem_s3  <= rem_s2;
			a_s3    <= ent_a;
			dn_s3   <= (ent_a >= ent_b);
			diff_s3 <= (ent_a >= ent_b) ? ent_a - ent_b : ent_b - ent_a;
			// s4: interpolation product
			it_s4   <= it_s3;
			n_s4    <= n_s3;
			a_s4    <= a_s3;
			dn_s4   <= dn_s3;
			prod_s4 <= diff_s3 * rem_s3;
			// s5: interpolated fraction, integer part lookup
			it_s5     <= it_s4;
			v_s5      <= dn_s4 ? a_s4 - step : a_s4 + step;
			it_val_s5 <= IT_TAB[n_s4];
			nz_s5     <= (n_s4 != 5'd0);
			// s6: exp(-n)*frac as two partial products
			it_s6  <= it_s5;
			v_s6   <= v_s5;
			nz_s6  <= nz_s5;
			pph_s6 <= it_val_s5 * v_s5[32:16];
			ppl_s6 <= it_val_s5 * v_s5[15:0];
			// s7: exponential
			it_s7 <= it_s6;
			ex_s7 <= nz_s6 ? ex_sum[64:32] : v_s6;
			// s8: cusp scaling partial products
			it_s8   <= it_s7;
			cneg_s8 <= cfg.cusp[23];
			cph_s8  <= cm * ex_s7[32:16];
			cpl_s8  <= cm * ex_s7[15:0];
			// s9: |e|
			it_s9   <= it_s8;
			emag_s9 <= e_sum[55:16];
			eneg_s9 <= cneg_s8 && (e_sum[55:16] != 40'd0);
			// s10: products for gradient and laplacian
			it_s10   <= it_s9;
			emag_s10 <= emag_s9;
			eneg_s10 <= eneg_s9;
			for (int k = 0; k < 3; k++) begin
				gph_s10[k] <= emag_s9[39:20] * it_s9.omag[k];
				gpl_s10[k] <= emag_s9[19:0] * it_s9.omag[k];
			end
			lbh_s10 <= cfg.decay * emag_s9[39:20];
			lbl_s10 <= cfg.decay * emag_s9[19:0];
			// s11: rounded numerators and side data
			it_s11 <= it_s10;
			for (int k = 0; k < 3; k++) begin
				gnum_s11[k] <= {gph_s10[k], 20'b0} + 64'(gpl_s10[k])
					+ 64'({it_s10.radius, 15'b0});
				side_s11.oz[k] <= (it_s10.omag[k] == 24'd0);
			end
			fnum_s11 <= 64'(emag_s10) + 64'(cfg.decay >> 1);
			lnum_s11 <= 64'({emag_s10, 1'b0}) + 64'(it_s10.radius >> 1);
			side_s11.eneg   <= eneg_s10;
			side_s11.ez     <= (emag_s10 == 40'd0);
			side_s11.r_zero <= it_s10.r_zero;
			side_s11.oneg   <= it_s10.oneg;
			side_s11.lap_b  <= lb_sum[64:32];
			// side data waits out the dividers
			side_line_q[0] <= side_s11;
			for (int k = 1; k < ecvgl_pkg::DIV_LAT; k++) side_line_q[k] <= side_line_q[k-1];
		end
	end

	ecvgl_div u_div_f (
		.clk (clk), .en (en), .num (fnum_s11),
		.den (ecvgl_pkg::DIV_DEN_W'(cfg.decay)), .quo (f_quo), .ovf (f_ovf)
	);

	ecvgl_div u_div_l (
		.clk (clk), .en (en), .num (lnum_s11),
		.den (ecvgl_pkg::DIV_DEN_W'(it_s11.radius)), .quo (l_quo), .ovf (l_ovf)
	);

	for (genvar k = 0; k < 3; k++) begin : g_grad
		ecvgl_div u_div_g (
			.clk (clk), .en (en), .num (gnum_s11[k]),
			.den ({it_s11.radius, 16'b0}), .quo (g_quo[k]), .ovf (g_ovf[k])
		);
	end

	function automatic logic signed [47:0] sat48(input logic neg, input logic sat,
		input logic [47:0] mag);
		logic signed [47:0] r;
		if (sat) r = neg ? ecvgl_pkg::NEG_MIN48 : ecvgl_pkg::POS_MAX48;
		else if (neg) r = (mag > 48'h8000_0000_0000) ? ecvgl_pkg::NEG_MIN48 : -$signed(mag);
		else r = (mag > 48'h7FFF_FFFF_FFFF) ? ecvgl_pkg::POS_MAX48 : $signed(mag);
		return r;
	endfunction

	assign sd = side_line_q[ecvgl_pkg::DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.func_value    <= sd.ez ? 48'sd0 : sat48(!sd.eneg, f_ovf, f_quo);
			res_q.grad_x        <= (sd.ez || sd.oz[0]) ? 48'sd0
				: sat48(sd.eneg ^ sd.oneg[0], g_ovf[0], g_quo[0]);
			res_q.grad_y        <= (sd.ez || sd.oz[1]) ? 48'sd0
				: sat48(sd.eneg ^ sd.oneg[1], g_ovf[1], g_quo[1]);
			res_q.grad_z        <= (sd.ez || sd.oz[2]) ? 48'sd0
				: sat48(sd.eneg ^ sd.oneg[2], g_ovf[2], g_quo[2]);
			res_q.zero_distance <= sd.r_zero;
			priority if (sd.r_zero || l_ovf) begin
				res_q.laplacian <= sd.ez ? 48'sd0 : sat48(sd.eneg, 1'b1, 48'd0);
			end else if (l_quo >= 48'(sd.lap_b)) begin
				res_q.laplacian <= sat48(sd.eneg, 1'b0, l_quo - 48'(sd.lap_b));
			end else begin
				res_q.laplacian <= sat48(!sd.eneg, 1'b0, 48'(sd.lap_b) - l_quo);
			end
		end
	end

endmodule

>>> rtl/exp_cusp_value_grad_lap_unit.sv
`timescale 1ns / 1ps
// throughput: one item per cycle while result beats are taken, set by the five 49-stage pipelined dividers
// the input register and a two-entry queue decouple input from the back pipeline
// reset (arst_n, asynchronous, active low) empties all stages and the queue
// and sets decay_rate and cusp_strength to 1.0; no clearing pass is needed
module exp_cusp_value_grad_lap_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        distance,
	input  logic signed [23:0] offset_x,
	input  logic signed [23:0] offset_y,
	input  logic signed [23:0] offset_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] func_value,
	output logic signed [47:0] grad_x,
	output logic signed [47:0] grad_y,
	output logic signed [47:0] grad_z,
	output logic signed [47:0] laplacian,
	output logic               zero_distance,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	ecvgl_pkg::cfg_t  cfg_q;
	ecvgl_pkg::item_t f_item;
	ecvgl_pkg::item_t q_item;
	ecvgl_pkg::res_t  res;
	logic             f_valid, f_ready;
	logic             q_valid, back_ready;
	logic             wr_en;

	// config port: zero wait states, register index in paddr[2]
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay <= ecvgl_pkg::DECAY_RESET;
			cfg_q.cusp  <= ecvgl_pkg::CUSP_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				ecvgl_pkg::REG_DECAY_RATE:    cfg_q.decay <= pwdata[23:0];
				ecvgl_pkg::REG_CUSP_STRENGTH: cfg_q.cusp  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ecvgl_pkg::REG_DECAY_RATE:    prdata = {8'b0, cfg_q.decay};
			ecvgl_pkg::REG_CUSP_STRENGTH: prdata = {8'b0, cfg_q.cusp};
			default:                      prdata = 32'd0;
		endcase
	end

	// front: take the beat, split offsets into sign and magnitude, flag r == 0
	ecvgl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.distance  (distance),
		.offset_x  (offset_x),
		.offset_y  (offset_y),
		.offset_z  (offset_z),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item)
	);

	// short queue so front and back stall independently
	ecvgl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (back_ready),
		.out_item  (q_item)
	);

	// back: exponential, scaling, products, dividers, saturation
	ecvgl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (q_valid),
		.in_ready  (back_ready),
		.in_item   (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign func_value    = res.func_value;
	assign grad_x        = res.grad_x;
	assign grad_y        = res.grad_y;
	assign grad_z        = res.grad_z;
	assign laplacian     = res.laplacian;
	assign zero_distance = res.zero_distance;

	// at zero distance the laplacian is either zero or pinned to a rail
	a_zero_lap_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_distance && (laplacian != 48'sd0) |->
			(laplacian == ecvgl_pkg::POS_MAX48) || (laplacian == ecvgl_pkg::NEG_MIN48))
		else $error("zero distance laplacian not saturated");

	// a queued item stays offered while the back pipeline is stalled
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !back_ready |=> q_valid)
		else $error("queue dropped an item under back stall");

	// back stalls only because a result beat is waiting
	a_back_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!back_ready |-> out_valid && !out_ready)
		else $error("back pipeline stalled without output backpressure");

endmodule
